[sv/snfcs_pkg.sv]
// Shared types and codes for the SPI NOR flash command sequencer.
// Used by the engine, the result register and the top level; no dependencies.
package snfcs_pkg;

  // Region sizes must be powers of two.
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int BLOCK_BYTES_DEF  = 65536;
  localparam int ADDRESS_BITS_DEF = 24;

  // Input item opcodes
  localparam logic [2:0] IN_READ    = 3'd0;
  localparam logic [2:0] IN_WRITE   = 3'd1;
  localparam logic [2:0] IN_ERASE   = 3'd2;
  localparam logic [2:0] IN_CHIP    = 3'd3;
  localparam logic [2:0] IN_JEDEC   = 3'd4;
  localparam logic [2:0] IN_UID     = 3'd5;
  localparam logic [2:0] IN_PAYLOAD = 3'd6;
  localparam logic [2:0] IN_REPLY   = 3'd7;

  // Operation held while a request runs
  localparam logic [2:0] OP_READ        = 3'd0;
  localparam logic [2:0] OP_WRITE       = 3'd1;
  localparam logic [2:0] OP_ERASE_SECTOR = 3'd2;
  localparam logic [2:0] OP_CHIP        = 3'd3;
  localparam logic [2:0] OP_JEDEC       = 3'd4;
  localparam logic [2:0] OP_UID         = 3'd5;
  localparam logic [2:0] OP_ERASE_BLOCK = 3'd6;

  // Region codes
  localparam logic [1:0] RG_PAGE   = 2'd0;
  localparam logic [1:0] RG_SECTOR = 2'd1;
  localparam logic [1:0] RG_BLOCK  = 2'd2;

  // Result kinds
  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_RELEASE = 3'd1;
  localparam logic [2:0] K_DATA    = 3'd2;
  localparam logic [2:0] K_DONE    = 3'd3;
  localparam logic [2:0] K_REJECT  = 3'd4;

  // Flash command bytes
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_FREAD   = 8'h0B;
  localparam logic [7:0] CMD_SE      = 8'h20;
  localparam logic [7:0] CMD_BE      = 8'hD8;
  localparam logic [7:0] CMD_CE      = 8'hC7;
  localparam logic [7:0] CMD_JEDEC   = 8'h9F;
  localparam logic [7:0] CMD_UID     = 8'h4B;
  localparam logic [7:0] SR_BUSY     = 8'h01;
  localparam logic [7:0] FILL_BYTE   = 8'h00;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  region;
    logic [15:0] unit_number;
    logic [15:0] start_offset;
    logic [16:0] byte_count;
    logic [7:0]  payload_byte;
    logic [7:0]  reply_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] byte_value;
    logic       frame_start;
    logic       last;
  } out_item_t;

  localparam int MAX_RESULTS = 3;

  // Up to three results produced by one input item
  typedef struct packed {
    logic [1:0]                       count;
    out_item_t [MAX_RESULTS-1:0]      item;
  } res_group_t;

endpackage

[sv/snfcs_engine.sv]
// Sequencer state machine: turns one input item into a group of up to three results.
// Depends on snfcs_pkg.
module snfcs_engine #(
  parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF,
  parameter int BLOCK_BYTES  = snfcs_pkg::BLOCK_BYTES_DEF,
  parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  snfcs_pkg::in_item_t    in_item,
  output snfcs_pkg::res_group_t  grp
);
  import snfcs_pkg::*;

  localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
  localparam int PAGE_LG    = $clog2(PAGE_BYTES);
  localparam int SEC_LG     = $clog2(SECTOR_BYTES);
  localparam int BLK_LG     = $clog2(BLOCK_BYTES);
  localparam int BRW        = $clog2(BLOCK_BYTES + 1);
  localparam int CKW        = $clog2(PAGE_BYTES + 1);
  localparam int CMW        = (BRW > 17) ? BRW : 17;
  localparam int AXW        = ADDRESS_BITS + 16;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WREN, PH_PRE_CMD, PH_PRE_STAT, PH_HDR, PH_DATA,
    PH_PAY_NEED, PH_PAY_WAIT, PH_POST_CMD, PH_POST_STAT
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [2:0]              op_r, op_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [BRW-1:0]          br_r, br_nxt;
  logic [CKW-1:0]          chunk_r, chunk_nxt;
  logic [2:0]              hc_r, hc_nxt;

  logic [CMW-1:0]          rs;
  logic [4:0]              rs_lg;
  logic [CMW-1:0]          len;
  logic [CMW-1:0]          off_w;
  logic [CMW-1:0]          cnt_w;
  logic [AXW-1:0]          unit_sh;
  logic                    req_op;

  function automatic res_group_t push(res_group_t g, logic [2:0] k, logic [7:0] v,
                                      logic fs);
    g.item[g.count] = '{result_kind: k, byte_value: v, frame_start: fs, last: 1'b0};
    g.count = g.count + 2'd1;
    return g;
  endfunction

  function automatic logic [2:0] hdr_len(logic [2:0] op);
    logic [2:0] l;
    case (op)
      OP_READ:                                 l = 3'(2 + ADDR_BYTES);
      OP_WRITE, OP_ERASE_SECTOR, OP_ERASE_BLOCK: l = 3'(1 + ADDR_BYTES);
      OP_UID:                                  l = 3'd5;
      default:                                 l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] hdr_byte(logic [2:0] op, logic [2:0] i,
                                          logic [ADDRESS_BITS-1:0] a);
    logic [31:0] a32;
    logic        addressed;
    logic [7:0]  b;
    a32 = 32'(a);
    addressed = (op == OP_READ) || (op == OP_WRITE) ||
                (op == OP_ERASE_SECTOR) || (op == OP_ERASE_BLOCK);
    b = FILL_BYTE;
    if (i == 3'd0) begin
      case (op)
        OP_READ:         b = CMD_FREAD;
        OP_WRITE:        b = CMD_PROGRAM;
        OP_ERASE_SECTOR: b = CMD_SE;
        OP_ERASE_BLOCK:  b = CMD_BE;
        OP_CHIP:         b = CMD_CE;
        OP_JEDEC:        b = CMD_JEDEC;
        default:         b = CMD_UID;
      endcase
    end else if (addressed && (i <= 3'(ADDR_BYTES))) begin
      // address goes out most significant byte first
      b = 8'(a32 >> (8 * (ADDR_BYTES - int'(i))));
    end
    return b;
  endfunction

  // bytes left in the current page, capped by what remains of the request
  function automatic logic [CKW-1:0] chunk_len(logic [ADDRESS_BITS-1:0] a,
                                               logic [BRW-1:0] br);
    logic [CKW-1:0] room;
    room = CKW'(PAGE_BYTES) - CKW'(a[PAGE_LG-1:0]);
    return (br < BRW'(room)) ? CKW'(br) : room;
  endfunction

  always_comb begin
    case (in_item.region)
      RG_PAGE:   begin rs = CMW'(PAGE_BYTES);   rs_lg = 5'(PAGE_LG); end
      RG_SECTOR: begin rs = CMW'(SECTOR_BYTES); rs_lg = 5'(SEC_LG);  end
      RG_BLOCK:  begin rs = CMW'(BLOCK_BYTES);  rs_lg = 5'(BLK_LG);  end
      default:   begin rs = '0;                 rs_lg = 5'd0;        end
    endcase
    off_w   = CMW'(in_item.start_offset);
    cnt_w   = CMW'(in_item.byte_count);
    len     = ((cnt_w == '0) || (cnt_w > rs)) ? rs : cnt_w;
    if (len > rs - off_w) len = rs - off_w;
    unit_sh = AXW'(in_item.unit_number) << rs_lg;
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    br_nxt    = br_r;
    chunk_nxt = chunk_r;
    hc_nxt    = hc_r;
    grp       = '0;
    req_op    = (in_item.opcode <= IN_UID);

    if (req_op) begin
      if (phase_r != PH_IDLE) begin
        grp = push(grp, K_REJECT, 8'h00, 1'b0);
      end else if ((in_item.opcode == IN_READ) || (in_item.opcode == IN_WRITE)) begin
        if (rs == '0) begin
          grp = push(grp, K_REJECT, 8'h00, 1'b0);
        end else if (off_w >= rs) begin
          grp = push(grp, K_DONE, 8'h00, 1'b0);
        end else begin
          op_nxt    = in_item.opcode;
          addr_nxt  = unit_sh[ADDRESS_BITS-1:0] + ADDRESS_BITS'(in_item.start_offset);
          br_nxt    = BRW'(len);
          chunk_nxt = chunk_len(addr_nxt, br_nxt);
          hc_nxt    = 3'd0;
          if (in_item.opcode == IN_READ) begin
            grp       = push(grp, K_SEND, hdr_byte(op_nxt, hc_nxt, addr_nxt), 1'b1);
            hc_nxt    = hc_nxt + 3'd1;
            phase_nxt = PH_HDR;
          end else begin
            grp       = push(grp, K_SEND, CMD_WREN, 1'b1);
            phase_nxt = PH_WREN;
          end
        end
      end else if (in_item.opcode == IN_ERASE) begin
        if ((in_item.region != RG_SECTOR) && (in_item.region != RG_BLOCK)) begin
          grp = push(grp, K_REJECT, 8'h00, 1'b0);
        end else begin
          op_nxt    = (in_item.region == RG_SECTOR) ? OP_ERASE_SECTOR : OP_ERASE_BLOCK;
          addr_nxt  = unit_sh[ADDRESS_BITS-1:0];
          hc_nxt    = 3'd0;
          grp       = push(grp, K_SEND, CMD_WREN, 1'b1);
          phase_nxt = PH_WREN;
        end
      end else begin
        op_nxt = in_item.opcode;
        hc_nxt = 3'd0;
        if (in_item.opcode == IN_CHIP) begin
          grp       = push(grp, K_SEND, CMD_WREN, 1'b1);
          phase_nxt = PH_WREN;
        end else begin
          grp       = push(grp, K_SEND, hdr_byte(op_nxt, hc_nxt, addr_nxt), 1'b1);
          hc_nxt    = hc_nxt + 3'd1;
          phase_nxt = PH_HDR;
        end
      end
    end else if (in_item.opcode == IN_PAYLOAD) begin
      if (phase_r == PH_PAY_NEED) begin
        grp       = push(grp, K_SEND, in_item.payload_byte, 1'b0);
        phase_nxt = PH_PAY_WAIT;
      end
    end else begin
      case (phase_r)
        PH_WREN: begin
          grp       = push(grp, K_RELEASE, 8'h00, 1'b0);
          grp       = push(grp, K_SEND, CMD_RDSR, 1'b1);
          phase_nxt = PH_PRE_CMD;
        end
        PH_PRE_CMD: begin
          grp       = push(grp, K_SEND, FILL_BYTE, 1'b0);
          phase_nxt = PH_PRE_STAT;
        end
        PH_PRE_STAT: begin
          if ((in_item.reply_byte & SR_BUSY) != 8'h00) begin
            grp = push(grp, K_SEND, FILL_BYTE, 1'b0);
          end else begin
            grp       = push(grp, K_RELEASE, 8'h00, 1'b0);
            grp       = push(grp, K_SEND, hdr_byte(op_r, 3'd0, addr_r), 1'b1);
            hc_nxt    = 3'd1;
            phase_nxt = PH_HDR;
          end
        end
        PH_HDR: begin
          if (hc_r < hdr_len(op_r)) begin
            grp    = push(grp, K_SEND, hdr_byte(op_r, hc_r, addr_r), hc_r == 3'd0);
            hc_nxt = hc_r + 3'd1;
          end else if (op_r == OP_WRITE) begin
            phase_nxt = PH_PAY_NEED;
          end else if ((op_r == OP_READ) || (op_r == OP_JEDEC) || (op_r == OP_UID)) begin
            if (op_r == OP_JEDEC) chunk_nxt = CKW'(3);
            if (op_r == OP_UID)   chunk_nxt = CKW'(8);
            grp       = push(grp, K_SEND, FILL_BYTE, 1'b0);
            phase_nxt = PH_DATA;
          end else begin
            grp       = push(grp, K_RELEASE, 8'h00, 1'b0);
            grp       = push(grp, K_SEND, CMD_RDSR, 1'b1);
            phase_nxt = PH_POST_CMD;
          end
        end
        PH_DATA: begin
          grp = push(grp, K_DATA, in_item.reply_byte, 1'b0);
          if (chunk_r != '0) chunk_nxt = chunk_r - CKW'(1);
          if (op_r == OP_READ) begin
            addr_nxt = addr_r + ADDRESS_BITS'(1);
            if (br_r != '0) br_nxt = br_r - BRW'(1);
          end
          if (chunk_nxt != '0) begin
            grp = push(grp, K_SEND, FILL_BYTE, 1'b0);
          end else begin
            grp = push(grp, K_RELEASE, 8'h00, 1'b0);
            if ((op_r == OP_READ) && (br_nxt != '0)) begin
              // next page of the read: fresh frame
              chunk_nxt = chunk_len(addr_nxt, br_nxt);
              grp       = push(grp, K_SEND, hdr_byte(op_r, 3'd0, addr_nxt), 1'b1);
              hc_nxt    = 3'd1;
              phase_nxt = PH_HDR;
            end else begin
              grp       = push(grp, K_DONE, 8'h00, 1'b0);
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_PAY_WAIT: begin
          if (chunk_r != '0) chunk_nxt = chunk_r - CKW'(1);
          if (br_r != '0)    br_nxt    = br_r - BRW'(1);
          addr_nxt = addr_r + ADDRESS_BITS'(1);
          if (chunk_nxt != '0) begin
            phase_nxt = PH_PAY_NEED;
          end else begin
            grp       = push(grp, K_RELEASE, 8'h00, 1'b0);
            grp       = push(grp, K_SEND, CMD_RDSR, 1'b1);
            phase_nxt = PH_POST_CMD;
          end
        end
        PH_POST_CMD: begin
          grp       = push(grp, K_SEND, FILL_BYTE, 1'b0);
          phase_nxt = PH_POST_STAT;
        end
        PH_POST_STAT: begin
          if ((in_item.reply_byte & SR_BUSY) != 8'h00) begin
            grp = push(grp, K_SEND, FILL_BYTE, 1'b0);
          end else begin
            grp = push(grp, K_RELEASE, 8'h00, 1'b0);
            if ((op_r == OP_WRITE) && (br_r != '0)) begin
              chunk_nxt = chunk_len(addr_r, br_r);
              hc_nxt    = 3'd0;
              grp       = push(grp, K_SEND, CMD_WREN, 1'b1);
              phase_nxt = PH_WREN;
            end else begin
              grp       = push(grp, K_DONE, 8'h00, 1'b0);
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end

    if (grp.count != 2'd0) grp.item[grp.count - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= '0;
      addr_r  <= '0;
      br_r    <= '0;
      chunk_r <= '0;
      hc_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      br_r    <= br_nxt;
      chunk_r <= chunk_nxt;
      hc_r    <= hc_nxt;
    end
  end

  // a request refused while busy leaves the sequence untouched
  a_busy_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_item.opcode <= IN_UID) && (phase_r != PH_IDLE)
      |=> $stable(phase_r) && $stable(addr_r) && $stable(br_r))
    else $error("request while busy changed the sequencer state");

  // a page chunk never exceeds what remains of a read or write
  a_chunk_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_PAY_NEED) || ((phase_r == PH_DATA) && (op_r == OP_READ)))
      |-> (BRW'(chunk_r) <= br_r))
    else $error("page chunk larger than remaining length");

endmodule

[sv/snfcs_result_reg.sv]
// Result register: holds one group of up to three results and hands them out in order.
// Depends on snfcs_pkg.
module snfcs_result_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  snfcs_pkg::res_group_t  grp,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output snfcs_pkg::out_item_t   out_item
);
  import snfcs_pkg::*;

  res_group_t grp_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       take;
  logic       last_take;

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = grp_r.item[idx_r];
  assign take      = out_valid && out_ready;
  assign last_take = take && (idx_r == cnt_r - 2'd1);
  // a new group may enter as the last result of the current one leaves
  assign free      = (cnt_r == 2'd0) || last_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load && free) begin
      cnt_r <= grp.count;
      idx_r <= 2'd0;
    end else if (last_take) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) grp_r <= grp;
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < cnt_r))
    else $error("result index past group size");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (out_item.last == (idx_r == cnt_r - 2'd1)))
    else $error("last flag does not match end of group");

  a_empty_group: assert property (@(posedge clk) disable iff (!rst_n)
    load && free && (grp.count == 2'd0) |=> !out_valid)
    else $error("empty group produced a result");

endmodule

[sv/spi_nor_flash_command_sequencer_core.sv]
// Top level of the single-IO SPI NOR flash command sequencer.
// Depends on snfcs_pkg, snfcs_engine and snfcs_result_reg.
//
// Usage:
//   in_*  : valid/ready channel of input items: requests (read, write, erase,
//           chip erase, JEDEC id, unique id), write payload bytes and the byte
//           shifted back from the flash for every byte sent.
//   out_* : valid/ready channel of results: byte to send (with frame_start),
//           chip-select release, read data, done or rejected. The last result
//           caused by an input item carries last.
//   An item is taken into an input register and held there until the result
//   register is free; the state machine then turns it into a group of zero
//   to three results that is loaded into the result register, from which
//   the first result is presented.
//   Throughput: one input item per cycle while each item causes at most one
//   result and out_ready is high; an item with several results holds the result
//   register until taken, so the output (one result per cycle) sets the rate.
//   When the receiver stalls, the result register holds and the input register
//   fills; in_ready then drops until the group drains.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and empties
//   both registers. No clearing pass is needed.
module spi_nor_flash_command_sequencer_core #(
  parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF,
  parameter int BLOCK_BYTES  = snfcs_pkg::BLOCK_BYTES_DEF,
  parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  snfcs_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output snfcs_pkg::out_item_t  out_item
);
  import snfcs_pkg::*;

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       free;
  logic       fire;
  res_group_t grp;

  assign fire     = in_vld_r && free;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_item;
  end

  snfcs_engine #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_item (in_item_r),
    .grp     (grp)
  );

  snfcs_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .grp       (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
